### rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants
// Command codes, channel words, cell control word and arithmetic helpers
// for the reverse-Polish calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int FUNC_W = 4;
    localparam int DATA_W = 32;
    localparam int DEPTH_OUT_W = 8;

    typedef enum logic [3:0] {
        FN_PUSH  = 4'd0,
        FN_ADD   = 4'd1,
        FN_SUB   = 4'd2,
        FN_MUL   = 4'd3,
        FN_DIV   = 4'd4,
        FN_REM   = 4'd5,
        FN_POP   = 4'd6,
        FN_PEEK  = 4'd7,
        FN_DUP   = 4'd8,
        FN_SWAP  = 4'd9,
        FN_CLEAR = 4'd10
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_PUSH,
        ST_OUT,
        ST_POP2
    } state_t;

    // shift command for the cell chain
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP,
        SH_LOAD_TOP
    } shift_t;

    typedef struct packed {
        shift_t             op;
        logic [DATA_W-1:0]  din;
    } cell_ctl_t;

    // command word
    typedef struct packed {
        func_t              func;
        logic [DATA_W-1:0]  operand_value;
    } cmd_word_t;

    // result word
    typedef struct packed {
        logic [DATA_W-1:0]      shown_value;
        logic                   shown_valid;
        logic                   underflow_flag;
        logic                   overflow_flag;
        logic                   div_zero_flag;
        logic [DEPTH_OUT_W-1:0] stack_depth;
    } res_word_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic [DATA_W-1:0] sat34(input logic signed [33:0] x);
        logic [DATA_W-1:0] r;
        if (x > 34'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (x < -34'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage

### rtl/core/rpn_stream_if.sv
// ----------------------------------------------------------------------------
// rpn_stream_if: valid/ready channel
// Carries one word per handshake with a generic payload.
// ----------------------------------------------------------------------------
interface rpn_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rpn_cell.sv
// ----------------------------------------------------------------------------
// rpn_cell: one stack cell
// Holds one entry and shifts with its neighbours on push and pop.
// ----------------------------------------------------------------------------
module rpn_cell (
    input  logic                        clk,
    input  rpn_pkg::shift_t             op,
    input  logic [rpn_pkg::DATA_W-1:0]  from_above,
    input  logic [rpn_pkg::DATA_W-1:0]  from_below,
    input  logic [rpn_pkg::DATA_W-1:0]  load_value,
    input  logic                        is_top,
    output logic [rpn_pkg::DATA_W-1:0]  value
);
    logic [rpn_pkg::DATA_W-1:0] data_reg;
    logic [rpn_pkg::DATA_W-1:0] data_next;

    // shift select
    always_comb
    begin
        case (op)
            rpn_pkg::SH_PUSH:     data_next = from_above;
            rpn_pkg::SH_POP:      data_next = from_below;
            rpn_pkg::SH_LOAD_TOP: data_next = is_top ? load_value : data_reg;
            default:              data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;
endmodule

### rtl/core/rpn_cell_chain.sv
// ----------------------------------------------------------------------------
// rpn_cell_chain: row of stack cells
// Cell 0 is the top of stack; pushes shift the row down, pops shift it up.
// ----------------------------------------------------------------------------
module rpn_cell_chain #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                        clk,
    input  rpn_pkg::cell_ctl_t          ctl,
    output logic [rpn_pkg::DATA_W-1:0]  top0,
    output logic [rpn_pkg::DATA_W-1:0]  top1
);
    logic [rpn_pkg::DATA_W-1:0] vals [STACK_DEPTH];

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++)
        begin : g_cell
            logic [rpn_pkg::DATA_W-1:0] above;
            logic [rpn_pkg::DATA_W-1:0] below;
            if (g == 0)
            begin : g_first
                assign above = ctl.din;
            end
            else
            begin : g_rest
                assign above = vals[g-1];
            end
            if (g == STACK_DEPTH-1)
            begin : g_last
                assign below = vals[g];
            end
            else
            begin : g_mid
                assign below = vals[g+1];
            end
            rpn_cell u_cell (
                .clk        (clk),
                .op         (ctl.op),
                .from_above (above),
                .from_below (below),
                .load_value (ctl.din),
                .is_top     (g == 0),
                .value      (vals[g])
            );
        end
    endgenerate

    assign top0 = vals[0];
    assign top1 = vals[1];
endmodule

### rtl/core/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse-Polish calculator on Q16.16 words
// Command sequencer over a shifting cell stack with a serial divider.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The stack is a row of cells
// that shift by one place per cycle, top in cell 0, so a command that pops
// two entries makes the second pop in ST_POP2. After acceptance, pop, peek,
// clear and unknown codes go to ST_OUT; push and dup via ST_PUSH; add and
// sub via ST_POP2, ST_PUSH; swap via ST_POP2 and ST_PUSH twice; mul via
// ST_POP2, ST_MUL, ST_DIVFIX, ST_PUSH; div by a nonzero divisor via ST_POP2,
// a one-bit-per-cycle restoring divider over 48 quotient bits in ST_DIV,
// ST_DIVFIX, ST_PUSH; rem likewise over 32 bits. Commands that find fewer
// than two entries skip the second pop. The output register holds the
// result until taken; the next command is accepted in the cycle after that.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    rpn_stream_if.sink    cmd,
    rpn_stream_if.source  res
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = rpn_pkg::DATA_W;
    localparam int QW = 48;

    rpn_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    rpn_pkg::func_t  func_reg, func_next;
    logic [DW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [63:0]     prod_reg, prod_next;
    logic [QW-1:0]   num_reg, num_next;       // |dividend| shifting out
    logic [DW:0]     rem_reg, rem_next;       // partial remainder
    logic [QW-1:0]   quo_reg, quo_next;
    logic [5:0]      step_reg, step_next;
    logic [DW-1:0]   div_abs_reg, div_abs_next;
    logic            neg_reg, neg_next;
    logic [DW-1:0]   push_reg, push_next;
    logic            push2_reg, push2_next;
    logic [DW-1:0]   push_b_reg, push_b_next;
    logic [DW-1:0]   shown_reg, shown_next;
    logic            sv_reg, sv_next, uf_reg, uf_next, of_reg, of_next;
    logic            dz_reg, dz_next;
    logic            out_valid_reg, out_valid_next;
    rpn_pkg::cell_ctl_t ctl;
    logic [DW-1:0]   top0, top1;

    rpn_cell_chain #(.STACK_DEPTH(STACK_DEPTH)) u_chain (
        .clk  (clk),
        .ctl  (ctl),
        .top0 (top0),
        .top1 (top1)
    );

    assign cmd.ready = (state_reg == rpn_pkg::ST_IDLE) && !out_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.data.shown_value    = shown_reg;
    assign res.data.shown_valid    = sv_reg;
    assign res.data.underflow_flag = uf_reg;
    assign res.data.overflow_flag  = of_reg;
    assign res.data.div_zero_flag  = dz_reg;
    assign res.data.stack_depth    = 8'(count_reg);

    // sequencer
    always_comb
    begin
        logic          has1, has2;
        logic [DW-1:0] v0, v1;
        logic [DW:0]   trial;
        logic signed [33:0] s;
        logic signed [63:0] pq;
        logic [QW:0]   qs;
        logic [DW-1:0] ta, tb;
        state_next = state_reg;  count_next = count_reg;  func_next = func_reg;
        a_next = a_reg;  b_next = b_reg;  prod_next = prod_reg;
        num_next = num_reg;  rem_next = rem_reg;  quo_next = quo_reg;
        step_next = step_reg;  div_abs_next = div_abs_reg;  neg_next = neg_reg;
        push_next = push_reg;  push2_next = push2_reg;  push_b_next = push_b_reg;
        shown_next = shown_reg;  sv_next = sv_reg;  uf_next = uf_reg;
        of_next = of_reg;  dz_next = dz_reg;  out_valid_next = out_valid_reg;
        ctl.op = rpn_pkg::SH_HOLD;
        ctl.din = push_reg;
        has1 = count_reg != '0;
        has2 = count_reg > CW'(1);
        v0 = has1 ? top0 : '0;
        v1 = has2 ? top1 : '0;
        trial = '0;  s = '0;  pq = '0;  qs = '0;  ta = '0;  tb = '0;
        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            rpn_pkg::ST_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    func_next = rpn_pkg::func_t'(cmd.data.func);
                    shown_next = '0;  sv_next = 1'b0;  uf_next = 1'b0;
                    of_next = 1'b0;  dz_next = 1'b0;  push2_next = 1'b0;
                    state_next = rpn_pkg::ST_OUT;
                    case (cmd.data.func)
                        rpn_pkg::FN_PUSH:
                        begin
                            push_next = cmd.data.operand_value;
                            state_next = rpn_pkg::ST_PUSH;
                        end
                        rpn_pkg::FN_ADD, rpn_pkg::FN_SUB, rpn_pkg::FN_MUL:
                        begin
                            uf_next = !has2;
                            ctl.op = rpn_pkg::SH_POP;
                            if (has2) count_next = count_reg - CW'(2);
                            else count_next = '0;
                            if (has2) ctl.op = rpn_pkg::SH_POP;
                            if (cmd.data.func == rpn_pkg::FN_ADD)
                                s = 34'(signed'(v1)) + 34'(signed'(v0));
                            else
                                s = 34'(signed'(v1)) - 34'(signed'(v0));
                            push_next = rpn_pkg::sat34(s);
                            a_next = v1;  b_next = v0;
                            if (cmd.data.func == rpn_pkg::FN_MUL)
                                state_next = rpn_pkg::ST_MUL;
                            else
                                state_next = rpn_pkg::ST_PUSH;
                            if (has2) state_next = rpn_pkg::ST_POP2;
                        end
                        rpn_pkg::FN_DIV, rpn_pkg::FN_REM:
                        begin
                            uf_next = !has1;
                            tb = DW'(signed'(v0) / 32'sd65536);
                            ta = DW'(signed'(v1) / 32'sd65536);
                            if ((cmd.data.func == rpn_pkg::FN_DIV) ? (v0 == '0)
                                                                   : (tb == '0))
                            begin
                                dz_next = 1'b1;
                                if (has1)
                                begin
                                    ctl.op = rpn_pkg::SH_POP;
                                    count_next = count_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                uf_next = !has2;
                                if (has2) count_next = count_reg - CW'(2);
                                else count_next = '0;
                                ctl.op = rpn_pkg::SH_POP;
                                if (cmd.data.func == rpn_pkg::FN_DIV)
                                begin
                                    num_next = v1[DW-1] ? QW'(-{16'(signed'(v1[DW-1])),
                                               v1, 16'h0}) : {v1, 16'h0};
                                    div_abs_next = v0[DW-1] ? -v0 : v0;
                                    neg_next = v1[DW-1] ^ v0[DW-1];
                                    step_next = 6'(QW);
                                end
                                else
                                begin
                                    num_next = {ta[DW-1] ? -ta : ta, 16'h0};
                                    div_abs_next = tb[DW-1] ? -tb : tb;
                                    neg_next = ta[DW-1];
                                    step_next = 6'(DW);
                                end
                                rem_next = '0;  quo_next = '0;
                                state_next = has2 ? rpn_pkg::ST_POP2 : rpn_pkg::ST_DIV;
                            end
                        end
                        rpn_pkg::FN_POP:
                        begin
                            sv_next = 1'b1;  shown_next = v0;  uf_next = !has1;
                            if (has1)
                            begin
                                ctl.op = rpn_pkg::SH_POP;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        rpn_pkg::FN_PEEK:
                        begin
                            sv_next = 1'b1;  shown_next = v0;  uf_next = !has1;
                        end
                        rpn_pkg::FN_DUP:
                        begin
                            uf_next = !has1;  push_next = v0;
                            state_next = rpn_pkg::ST_PUSH;
                        end
                        rpn_pkg::FN_SWAP:
                        begin
                            uf_next = !has2;
                            if (has2) count_next = count_reg - CW'(2);
                            else count_next = '0;
                            ctl.op = rpn_pkg::SH_POP;
                            push_next = v0;  push_b_next = v1;  push2_next = 1'b1;
                            state_next = has2 ? rpn_pkg::ST_POP2 : rpn_pkg::ST_PUSH;
                        end
                        rpn_pkg::FN_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            rpn_pkg::ST_POP2:
            begin
                // second shift of a two-entry pop
                ctl.op = rpn_pkg::SH_POP;
                case (func_reg)
                    rpn_pkg::FN_MUL:                 state_next = rpn_pkg::ST_MUL;
                    rpn_pkg::FN_DIV, rpn_pkg::FN_REM: state_next = rpn_pkg::ST_DIV;
                    default:                         state_next = rpn_pkg::ST_PUSH;
                endcase
            end
            rpn_pkg::ST_MUL:
            begin
                // registered 32x32 product, floor shift next
                prod_next = 64'(signed'(a_reg) * signed'(b_reg));
                state_next = rpn_pkg::ST_DIVFIX;
            end
            rpn_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                trial = {rem_reg[DW-1:0], num_reg[QW-1]};
                num_next = {num_reg[QW-2:0], 1'b0};
                if (trial >= {1'b0, div_abs_reg})
                begin
                    rem_next = trial - {1'b0, div_abs_reg};
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd1)
                    state_next = rpn_pkg::ST_DIVFIX;
            end
            rpn_pkg::ST_DIVFIX:
            begin
                state_next = rpn_pkg::ST_PUSH;
                if (func_reg == rpn_pkg::FN_MUL)
                begin
                    pq = signed'(prod_reg) >>> 16;
                    if (pq > 64'sh7FFF_FFFF) push_next = 32'h7FFF_FFFF;
                    else if (pq < -64'sh8000_0000) push_next = 32'h8000_0000;
                    else push_next = pq[DW-1:0];
                end
                else if (func_reg == rpn_pkg::FN_DIV)
                begin
                    qs = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
                    if (!neg_reg && quo_reg > QW'(32'h7FFF_FFFF))
                        push_next = 32'h7FFF_FFFF;
                    else if (neg_reg && quo_reg > QW'(33'h1_0000_0000 - 33'd1) + QW'(1))
                        push_next = 32'h8000_0000;
                    else if (neg_reg && quo_reg >= QW'(33'h0_8000_0000))
                        push_next = 32'h8000_0000;
                    else
                        push_next = qs[DW-1:0];
                end
                else
                begin
                    // remainder magnitude in rem_reg, sign of dividend
                    ta = rem_reg[DW-1:0];
                    tb = neg_reg ? -ta : ta;
                    push_next = {tb[15:0], 16'h0};
                end
            end
            rpn_pkg::ST_PUSH:
            begin
                if (count_reg < CW'(STACK_DEPTH))
                begin
                    ctl.op = rpn_pkg::SH_PUSH;
                    ctl.din = push_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                    of_next = 1'b1;
                if (push2_reg)
                begin
                    push2_next = 1'b0;
                    push_next = push_b_reg;
                end
                else
                    state_next = rpn_pkg::ST_OUT;
            end
            rpn_pkg::ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = rpn_pkg::ST_IDLE;
            end
            default: state_next = rpn_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::ST_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            step_reg <= '0;
            push2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            step_reg <= step_next;
            push2_reg <= push2_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;  a_reg <= a_next;  b_reg <= b_next;
        prod_reg <= prod_next;  num_reg <= num_next;  rem_reg <= rem_next;
        quo_reg <= quo_next;  div_abs_reg <= div_abs_next;  neg_reg <= neg_next;
        push_reg <= push_next;  push_b_reg <= push_b_next;
        shown_reg <= shown_next;  sv_reg <= sv_next;  uf_reg <= uf_next;
        of_reg <= of_next;  dz_reg <= dz_next;
    end
endmodule
